[rtl/core/srbl_pkg.sv]
package srbl_pkg;

    localparam int MAX_BLOCKS_DEF = 6;
    localparam int SEQ_W          = 32;
    localparam int LIST_CNT_W     = 3;

    typedef logic [SEQ_W-1:0] seq_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch an accepted item
        logic step;     // handle one stored block of the walk
        logic commit;   // settle the new head block and the count
        logic emit;     // load the next result into the output register
    } srbl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic skip;       // clear or bad range: no walk
        logic walk_done;  // every stored block has been handled
        logic emit_last;  // the next result is the final one of the item
        logic out_free;   // output register can take a result this cycle
    } srbl_status_t;

    // a precedes b, modulo 2^32
    function automatic logic seq_lt(input seq_t a, input seq_t b);
        seq_t d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

[rtl/core/srbl_in_if.sv]
interface srbl_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    srbl_pkg::seq_t       seg_start;
    srbl_pkg::seq_t       seg_end;
    srbl_pkg::seq_t       next_expected;

    modport source (output valid, output mode, output seg_start, output seg_end,
                    output next_expected, input ready);
    modport sink   (input valid, input mode, input seg_start, input seg_end,
                    input next_expected, output ready);
endinterface

[rtl/core/srbl_out_if.sv]
interface srbl_out_if;
    logic                              valid;
    logic                              ready;
    srbl_pkg::seq_t                    blk_start;
    srbl_pkg::seq_t                    blk_end;
    logic                              blk_valid;
    logic [srbl_pkg::LIST_CNT_W-1:0]   list_count;
    logic                              bad_range;
    logic                              last;

    modport source (output valid, output blk_start, output blk_end, output blk_valid,
                    output list_count, output bad_range, output last, input ready);
    modport sink   (input valid, input blk_start, input blk_end, input blk_valid,
                    input list_count, input bad_range, input last, output ready);
endinterface

[rtl/core/sack_receive_block_list_top.sv]
// Receiver SACK block list of up to MAX_BLOCKS ranges with modulo-2^32
// sequence compares. Each accepted item (update or clear) yields one result
// per held block, or a single empty result, with last set on the final one.
// One item at a time: the accept, then for an update one walk step per stored
// block plus one commit step (a clear or a bad range passes the walk state
// with neither), then one result per emit step, held while the sink stalls;
// the walk and the result readout share the single read port of the block
// store. A result held in the output register does not block the next
// item from being accepted.
module sack_receive_block_list_top #(
    parameter int MAX_BLOCKS = srbl_pkg::MAX_BLOCKS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    srbl_in_if.sink    seg_in,
    srbl_out_if.source blk_out
);

    srbl_pkg::srbl_cmd_t    cmd;
    srbl_pkg::srbl_status_t status;
    logic                   in_ready;

    assign seg_in.ready = in_ready;

    srbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seg_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srbl_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (seg_in.mode),
        .seg_start     (seg_in.seg_start),
        .seg_end       (seg_in.seg_end),
        .next_expected (seg_in.next_expected),
        .cmd           (cmd),
        .status        (status),
        .out_ch        (blk_out)
    );

    // no second item while the current one is still in work
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg_in.valid && seg_in.ready) |=> !seg_in.ready)
        else $error("input accepted again before item finished");

    // an empty result is the only result of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (blk_out.valid && !blk_out.blk_valid) |-> (blk_out.last && blk_out.list_count == '0))
        else $error("empty result not final or with nonzero count");

    // a result is emitted only while the datapath has room for it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an unaccepted one");

    // walking, committing and emitting never overlap a load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.step && !cmd.commit && !cmd.emit))
        else $error("load overlaps other datapath command");

endmodule

[rtl/core/srbl_ctrl.sv]
module srbl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  srbl_pkg::srbl_status_t status,
    output srbl_pkg::srbl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (status.skip)
                begin
                    state_next = S_EMIT;
                end
                else if (status.walk_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/srbl_datapath.sv]
module srbl_datapath #(
    parameter int MAX_BLOCKS = srbl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mode,
    input  srbl_pkg::seq_t         seg_start,
    input  srbl_pkg::seq_t         seg_end,
    input  srbl_pkg::seq_t         next_expected,
    input  srbl_pkg::srbl_cmd_t    cmd,
    output srbl_pkg::srbl_status_t status,
    srbl_out_if.source             out_ch
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    srbl_pkg::seq_t starts_reg [MAX_BLOCKS];
    srbl_pkg::seq_t ends_reg   [MAX_BLOCKS];

    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  nk_reg, nk_next;
    srbl_pkg::seq_t nxt_reg, nxt_next;
    srbl_pkg::seq_t hs_reg, hs_next;
    srbl_pkg::seq_t he_reg, he_next;
    logic           bad_reg, bad_next;
    logic           skip_reg, skip_next;

    logic                            out_valid_reg, out_valid_next;
    srbl_pkg::seq_t                  out_start_reg;
    srbl_pkg::seq_t                  out_end_reg;
    logic                            out_blk_valid_reg;
    logic [srbl_pkg::LIST_CNT_W-1:0] out_count_reg;
    logic                            out_bad_reg;
    logic                            out_last_reg;

    logic [IW-1:0]  rd_idx;
    srbl_pkg::seq_t bs, be;
    logic           ent_drop, ent_merge, ent_keep;
    logic           head_new;
    logic           list_nonempty;
    logic           last_now;
    logic           seg_bad;

    assign rd_idx = idx_reg[IW-1:0];
    assign bs     = starts_reg[rd_idx];
    assign be     = ends_reg[rd_idx];

    assign ent_drop  = !srbl_pkg::seq_lt(bs, be) || (bs == nxt_reg)
                       || srbl_pkg::seq_lt(bs, nxt_reg);
    assign ent_merge = ((hs_reg == be) || srbl_pkg::seq_lt(hs_reg, be))
                       && ((bs == he_reg) || srbl_pkg::seq_lt(bs, he_reg));
    assign ent_keep  = !ent_drop && !ent_merge;
    assign head_new  = srbl_pkg::seq_lt(nxt_reg, hs_reg);

    assign list_nonempty = (count_reg != '0);
    assign last_now      = !list_nonempty || ((idx_reg + CW'(1)) == count_reg);
    assign seg_bad       = !mode && !srbl_pkg::seq_lt(seg_start, seg_end);

    assign status.skip      = skip_reg;
    assign status.walk_done = (idx_reg == count_reg);
    assign status.emit_last = last_now;
    assign status.out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        nk_next        = nk_reg;
        nxt_next       = nxt_reg;
        hs_next        = hs_reg;
        he_next        = he_reg;
        bad_next       = bad_reg;
        skip_next      = skip_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;

        if (cmd.load)
        begin
            nxt_next  = next_expected;
            hs_next   = seg_start;
            he_next   = seg_end;
            idx_next  = '0;
            nk_next   = '0;
            bad_next  = seg_bad;
            skip_next = mode || seg_bad;
            if (mode)
            begin
                count_next = '0;
            end
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + CW'(1);
            if (!ent_drop && ent_merge)
            begin
                if (srbl_pkg::seq_lt(bs, hs_reg))
                begin
                    hs_next = bs;
                end
                if (srbl_pkg::seq_lt(he_reg, be))
                begin
                    he_next = be;
                end
            end
            else if (ent_keep)
            begin
                nk_next = nk_reg + CW'(1);
            end
        end

        if (cmd.commit)
        begin
            idx_next = '0;
            if (head_new)
            begin
                // the oldest kept block falls off a full list
                if (nk_reg == CW'(MAX_BLOCKS))
                begin
                    count_next = CW'(MAX_BLOCKS);
                end
                else
                begin
                    count_next = nk_reg + CW'(1);
                end
            end
            else
            begin
                count_next = nk_reg;
            end
        end

        if (cmd.emit)
        begin
            idx_next       = idx_reg + CW'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            nk_reg        <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            nk_reg        <= nk_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_reg <= nxt_next;
        hs_reg  <= hs_next;
        he_reg  <= he_next;
        bad_reg <= bad_next;
        if (cmd.emit)
        begin
            out_blk_valid_reg <= list_nonempty;
            out_start_reg     <= list_nonempty ? bs : '0;
            out_end_reg       <= list_nonempty ? be : '0;
            out_count_reg     <= srbl_pkg::LIST_CNT_W'(count_reg);
            out_bad_reg       <= bad_reg;
            out_last_reg      <= last_now;
        end
    end

    // Kept blocks compact in place: the write slot never passes the read slot.
    always_ff @(posedge clk)
    begin
        if (cmd.step && ent_keep)
        begin
            starts_reg[nk_reg[IW-1:0]] <= bs;
            ends_reg[nk_reg[IW-1:0]]   <= be;
        end
        else if (cmd.commit && head_new)
        begin
            for (int j = MAX_BLOCKS - 1; j > 0; j--)
            begin
                starts_reg[j] <= starts_reg[j-1];
                ends_reg[j]   <= ends_reg[j-1];
            end
            starts_reg[0] <= hs_reg;
            ends_reg[0]   <= he_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.blk_start  = out_start_reg;
    assign out_ch.blk_end    = out_end_reg;
    assign out_ch.blk_valid  = out_blk_valid_reg;
    assign out_ch.list_count = out_count_reg;
    assign out_ch.bad_range  = out_bad_reg;
    assign out_ch.last       = out_last_reg;

endmodule
